// ===== hw/rtl/nspc_pkg.sv =====
// shared types, codes and widths of the nearest signature pixel classifier
package nspc_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int SLOT_W    = 6;
    localparam int COMP_W    = 16;
    localparam int ENT_W     = 3 * COMP_W;
    localparam int MASK_W    = 8;
    localparam int COUNT_W   = 7;
    localparam int SQ_W      = 32;
    localparam int DIST_W    = 34;
    localparam int CFG_IDX_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD_BG  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_FG  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SIZE = 2'd2;

    // mask codes
    localparam logic [MASK_W-1:0] MASK_BG      = 8'd0;
    localparam logic [MASK_W-1:0] MASK_FG      = 8'd254;
    localparam logic [MASK_W-1:0] MASK_SURE_FG = 8'd255;

    // distance constants
    localparam logic [DIST_W-1:0] DIST_EPS = 34'd1;
    localparam logic [DIST_W-1:0] DIST_MAX = 34'h3_FFFF_FFFF;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BG,
        S_FG,
        S_DRAIN,
        S_FIXUP,
        S_FINISH
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_bg;
        logic load_fg;
        logic latch_px;
        logic pass;
        logic rd_en;
        logic rd_fg;
        logic rd_first;
        logic fixup;
        logic finish;
    } t_cmd;

endpackage

// ===== hw/rtl/nspc_ctrl.sv =====
// controller: accepts beats, sequences table sweeps and result formation
module nspc_ctrl #(
    parameter int SIG_DEPTH = 64,
    parameter int IDX_W     = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [nspc_pkg::OP_W-1:0]    i_op,
    input  logic [nspc_pkg::SLOT_W-1:0]  i_slot,
    input  logic [nspc_pkg::MASK_W-1:0]  i_mask_in,
    input  logic [nspc_pkg::COUNT_W-1:0] i_bg_count,
    input  logic [nspc_pkg::COUNT_W-1:0] i_fg_count,
    input  logic                         i_pipe_busy,
    output nspc_pkg::t_cmd               o_cmd,
    output logic [IDX_W-1:0]             o_rd_addr,
    output logic                         o_busy
);
    import nspc_pkg::*;

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [COUNT_W-1:0] w_nbg, w_nfg;
    logic               w_accept;
    logic               w_slot_ok;
    logic               w_pass;
    logic               w_last_bg, w_last_fg;

    // entries in use, clipped to the table depth
    assign w_nbg = (32'(i_bg_count) > SIG_DEPTH) ? COUNT_W'(SIG_DEPTH) : i_bg_count;
    assign w_nfg = (32'(i_fg_count) > SIG_DEPTH) ? COUNT_W'(SIG_DEPTH) : i_fg_count;

    assign w_accept  = i_start && (r_state == S_IDLE);
    assign w_slot_ok = 32'(i_slot) < SIG_DEPTH;
    assign w_pass    = (i_mask_in == MASK_BG) || (i_mask_in == MASK_SURE_FG)
                       || (w_nbg == '0);
    assign w_last_bg = (r_cnt == w_nbg - COUNT_W'(1));
    assign w_last_fg = (r_cnt == w_nfg - COUNT_W'(1));

    // state and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_accept && (i_op == OP_CLASSIFY) && !w_pass) begin
                    n_state = S_BG;
                end
            end
            S_BG: begin
                if (w_last_bg) begin
                    n_cnt   = '0;
                    n_state = (w_nfg != '0) ? S_FG : S_DRAIN;
                end else begin
                    n_cnt = r_cnt + COUNT_W'(1);
                end
            end
            S_FG: begin
                if (w_last_fg) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + COUNT_W'(1);
                end
            end
            S_DRAIN: begin
                if (!i_pipe_busy) begin
                    n_state = (w_nfg == '0) ? S_FIXUP : S_FINISH;
                end
            end
            S_FIXUP: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_bg  = (i_op == OP_LOAD_BG) && w_slot_ok;
                    o_cmd.load_fg  = (i_op == OP_LOAD_FG) && w_slot_ok;
                    o_cmd.latch_px = (i_op == OP_CLASSIFY) && !w_pass;
                    o_cmd.pass     = (i_op == OP_CLASSIFY) && w_pass;
                end
            end
            S_BG: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_first = (r_cnt == '0);
            end
            S_FG: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_fg    = 1'b1;
                o_cmd.rd_first = (r_cnt == '0);
            end
            S_DRAIN: begin
            end
            S_FIXUP: begin
                o_cmd.fixup = 1'b1;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_rd_addr = IDX_W'(r_cnt);
    assign o_busy    = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/nspc_datapath.sv =====
// datapath: centroid tables, distance pipeline, minimum tracking, result register
module nspc_datapath #(
    parameter int SIG_DEPTH = 64,
    parameter int IDX_W     = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  nspc_pkg::t_cmd                     i_cmd,
    input  logic [IDX_W-1:0]                   i_rd_addr,
    input  logic [nspc_pkg::SLOT_W-1:0]        i_slot,
    input  logic signed [nspc_pkg::COMP_W-1:0] i_lum,
    input  logic signed [nspc_pkg::COMP_W-1:0] i_chroma_a,
    input  logic signed [nspc_pkg::COMP_W-1:0] i_chroma_b,
    input  logic [nspc_pkg::MASK_W-1:0]        i_mask_in,
    input  logic [nspc_pkg::DIST_W-1:0]        i_cluster_size,
    output logic                               o_pipe_busy,
    output logic                               o_valid,
    output logic [nspc_pkg::MASK_W-1:0]        o_mask_out,
    output logic [nspc_pkg::DIST_W-1:0]        o_bg_dist,
    output logic [nspc_pkg::DIST_W-1:0]        o_fg_dist,
    output logic                               o_classified
);
    import nspc_pkg::*;

    logic [ENT_W-1:0]         r_bg_mem [SIG_DEPTH];
    logic [ENT_W-1:0]         r_fg_mem [SIG_DEPTH];
    logic [ENT_W-1:0]         r_rd;
    logic signed [COMP_W-1:0] r_px [3];
    logic signed [COMP_W-1:0] w_ent [3];
    logic signed [COMP_W:0]   w_diff [3];
    logic [COMP_W-1:0]        w_abs [3];
    logic [SQ_W-1:0]          r_s2_sq [3];
    logic [DIST_W-1:0]        r_s3_d;
    logic                     r_s1_v, r_s2_v, r_s3_v;
    logic                     r_s1_fg, r_s2_fg, r_s3_fg;
    logic                     r_s1_first, r_s2_first, r_s3_first;
    logic [DIST_W-1:0]        r_bg_best, r_fg_best;
    logic [DIST_W:0]          w_fix_sum;
    logic [DIST_W-1:0]        w_fix_sat;
    logic [IDX_W-1:0]         w_wr_addr;
    logic [ENT_W-1:0]         w_wr_data;
    logic                     r_valid;
    logic [MASK_W-1:0]        r_mask_out;
    logic [DIST_W-1:0]        r_bg_dist, r_fg_dist;
    logic                     r_classified;

    assign w_wr_addr = IDX_W'(i_slot);
    assign w_wr_data = {i_lum, i_chroma_a, i_chroma_b};

    // table writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_bg) begin
            r_bg_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.load_fg) begin
            r_fg_mem[w_wr_addr] <= w_wr_data;
        end
    end

    // registered table read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            if (i_cmd.rd_fg) begin
                r_rd <= r_fg_mem[i_rd_addr];
            end else begin
                r_rd <= r_bg_mem[i_rd_addr];
            end
        end
    end

    // pixel colour held for the sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_px) begin
            r_px[0] <= i_lum;
            r_px[1] <= i_chroma_a;
            r_px[2] <= i_chroma_b;
        end
    end

    // pipeline tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.rd_en;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_fg    <= i_cmd.rd_fg;
        r_s1_first <= i_cmd.rd_first;
        r_s2_fg    <= r_s1_fg;
        r_s2_first <= r_s1_first;
        r_s3_fg    <= r_s2_fg;
        r_s3_first <= r_s2_first;
    end

    assign o_pipe_busy = r_s1_v || r_s2_v || r_s3_v;

    // per-component absolute difference
    assign w_ent[0] = signed'(r_rd[ENT_W-1 -: COMP_W]);
    assign w_ent[1] = signed'(r_rd[2*COMP_W-1 -: COMP_W]);
    assign w_ent[2] = signed'(r_rd[COMP_W-1:0]);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_diff[i] = (COMP_W+1)'(r_px[i]) - (COMP_W+1)'(w_ent[i]);
            w_abs[i]  = w_diff[i][COMP_W] ? COMP_W'(-w_diff[i]) : w_diff[i][COMP_W-1:0];
        end
    end

    // squares
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s2_sq[i] <= SQ_W'(w_abs[i]) * SQ_W'(w_abs[i]);
        end
    end

    // distance sum
    always_ff @(posedge i_clk) begin
        r_s3_d <= DIST_W'(r_s2_sq[0]) + DIST_W'(r_s2_sq[1]) + DIST_W'(r_s2_sq[2]);
    end

    // empty foreground table: distance derived from cluster size and the background minimum
    assign w_fix_sum = {1'b0, r_bg_best} + {1'b0, i_cluster_size};
    assign w_fix_sat = w_fix_sum[DIST_W] ? DIST_MAX : w_fix_sum[DIST_W-1:0];

    // running minimum per table
    always_ff @(posedge i_clk) begin
        if (r_s3_v && !r_s3_fg) begin
            if (r_s3_first || (r_s3_d < r_bg_best)) begin
                r_bg_best <= r_s3_d;
            end
        end
        if (r_s3_v && r_s3_fg) begin
            if (r_s3_first || (r_s3_d < r_fg_best)) begin
                r_fg_best <= r_s3_d;
            end
        end else if (i_cmd.fixup) begin
            r_fg_best <= (r_bg_best < i_cluster_size) ? w_fix_sat : DIST_EPS;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.pass || i_cmd.finish;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.pass) begin
            r_mask_out   <= i_mask_in;
            r_bg_dist    <= '0;
            r_fg_dist    <= '0;
            r_classified <= 1'b0;
        end else if (i_cmd.finish) begin
            r_mask_out   <= (r_bg_best >= r_fg_best) ? MASK_FG : MASK_BG;
            r_bg_dist    <= r_bg_best;
            r_fg_dist    <= r_fg_best;
            r_classified <= 1'b1;
        end
    end

    assign o_valid      = r_valid;
    assign o_mask_out   = r_mask_out;
    assign o_bg_dist    = r_bg_dist;
    assign o_fg_dist    = r_fg_dist;
    assign o_classified = r_classified;

endmodule

// ===== hw/rtl/nearest_signature_pixel_classifier_top.sv =====
// top level of the nearest signature pixel classifier: registers, controller, datapath
//
// A beat is taken when i_start is high and o_busy is low. Load beats (op 0/1)
// write one centroid entry and give no result. A classify beat
// for a sure pixel (mask 0 or 255) or with an empty background table gives its
// result on the next cycle. Any other classify beat sweeps the background and
// then the foreground table through a single distance pipeline, one entry per
// cycle, over the background and foreground entry counts clipped to SIG_DEPTH,
// with a fix-up step when the foreground table is empty; o_busy stays high
// until the sweep drains, and the result appears in the cycle o_busy falls.
// The next beat may be given in that same cycle. Each result is shown for one
// cycle under o_valid and must be taken then; the receiver cannot stall.
// Configuration writes are not held off, so give them only while the block is idle.
module nearest_signature_pixel_classifier_top #(
    parameter int SIG_DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [nspc_pkg::OP_W-1:0]          i_op,
    input  logic [nspc_pkg::SLOT_W-1:0]        i_slot,
    input  logic signed [nspc_pkg::COMP_W-1:0] i_lum,
    input  logic signed [nspc_pkg::COMP_W-1:0] i_chroma_a,
    input  logic signed [nspc_pkg::COMP_W-1:0] i_chroma_b,
    input  logic [nspc_pkg::MASK_W-1:0]        i_mask_in,
    input  logic                               i_cfg_we,
    input  logic [nspc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [nspc_pkg::DIST_W-1:0]        i_cfg_data,
    output logic                               o_valid,
    output logic [nspc_pkg::MASK_W-1:0]        o_mask_out,
    output logic [nspc_pkg::DIST_W-1:0]        o_bg_dist,
    output logic [nspc_pkg::DIST_W-1:0]        o_fg_dist,
    output logic                               o_classified
);
    import nspc_pkg::*;

    localparam int IDX_W = (SIG_DEPTH > 1) ? $clog2(SIG_DEPTH) : 1;

    logic [COUNT_W-1:0] r_bg_count, r_fg_count;
    logic [DIST_W-1:0]  r_cluster_size;
    t_cmd               w_cmd;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_pipe_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_count     <= '0;
            r_fg_count     <= '0;
            r_cluster_size <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BG_COUNT) begin
                r_bg_count <= i_cfg_data[COUNT_W-1:0];
            end
            if (i_cfg_idx == CFG_FG_COUNT) begin
                r_fg_count <= i_cfg_data[COUNT_W-1:0];
            end
            if (i_cfg_idx == CFG_CLUSTER_SIZE) begin
                r_cluster_size <= i_cfg_data;
            end
        end
    end

    // controller
    nspc_ctrl #(
        .SIG_DEPTH (SIG_DEPTH),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_op        (i_op),
        .i_slot      (i_slot),
        .i_mask_in   (i_mask_in),
        .i_bg_count  (r_bg_count),
        .i_fg_count  (r_fg_count),
        .i_pipe_busy (w_pipe_busy),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr),
        .o_busy      (o_busy)
    );

    // datapath
    nspc_datapath #(
        .SIG_DEPTH (SIG_DEPTH),
        .IDX_W     (IDX_W)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_rd_addr      (w_rd_addr),
        .i_slot         (i_slot),
        .i_lum          (i_lum),
        .i_chroma_a     (i_chroma_a),
        .i_chroma_b     (i_chroma_b),
        .i_mask_in      (i_mask_in),
        .i_cluster_size (r_cluster_size),
        .o_pipe_busy    (w_pipe_busy),
        .o_valid        (o_valid),
        .o_mask_out     (o_mask_out),
        .o_bg_dist      (o_bg_dist),
        .o_fg_dist      (o_fg_dist),
        .o_classified   (o_classified)
    );

`ifndef SYNTH
    // a classified result arrives only once the sweep has ended
    a_classified_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_classified) |-> !o_busy)
        else $error("classified result while busy");

    // classified results carry one of the two decision codes
    a_classified_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_classified) |-> ((o_mask_out == MASK_FG) || (o_mask_out == MASK_BG)))
        else $error("classified mask is not a decision code");

    // pass-through results carry zero distances
    a_pass_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_classified) |-> ((o_bg_dist == '0) && (o_fg_dist == '0)))
        else $error("pass-through result with nonzero distance");

    // a sure pixel comes back unchanged on the next cycle
    a_sure_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_op == OP_CLASSIFY)
         && ((i_mask_in == MASK_BG) || (i_mask_in == MASK_SURE_FG)))
        |=> (o_valid && !o_classified && (o_mask_out == $past(i_mask_in))))
        else $error("sure pixel not passed through");
`endif

endmodule
